// File: src/bba_pkg.sv
`timescale 1ns / 1ps
package bba_pkg;

    localparam int MAX_ORDER  = 10;
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
    localparam int UNIT_W     = MAX_ORDER;          // unit address width
    localparam int IDX_W      = MAX_ORDER + 1;      // tree node index width
    localparam int WBITS      = 32;                 // node flags per memory word
    localparam int WSEL_W     = $clog2(WBITS);
    localparam int WADR_W     = IDX_W - WSEL_W;     // node memory word address
    localparam int NWORDS     = 1 << WADR_W;
    localparam int NUNITS     = 1 << UNIT_W;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_OOM      = 2'd2,
        ST_INV_FREE = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        S_CLR, S_ROOT, S_IDLE, S_DEC,
        S_SCAN_RD, S_SCAN_CHK, S_TAKE_RD, S_TAKE_WR,
        S_SPLIT_PREP, S_SPLIT_RD, S_SPLIT_WR, S_UNIT_WR,
        S_UNIT_RD, S_FR_CHK, S_MG_PREP, S_MG_RD, S_MG_CHK,
        S_SET_PREP, S_SET_RD, S_SET_WR, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLR, OP_ROOT, OP_CAP, OP_DEC,
        OP_SCAN_RD, OP_SCAN_CHK, OP_NODE_RD, OP_TAKE_WR,
        OP_SPLIT_PREP, OP_SPLIT_WR, OP_UNIT_WR, OP_UNIT_RD,
        OP_FR_CHK, OP_MG_PREP, OP_MG_CHK
    } t_op;

    // second group of ops kept apart to stay in 4 bits above
    typedef enum logic [1:0] {
        OPX_NONE, OPX_SET_PREP, OPX_SET_WR, OPX_OUT
    } t_opx;

    typedef struct packed {
        t_op  op;
        t_opx opx;
    } t_dp_cmd;

    typedef struct packed {
        logic dec_err;
        logic fr_err;
        logic is_free;
        logic hit;
        logic more;
        logic merge_ok;
        logic buddy_free;
        logic clr_done;
        logic out_free;
    } t_dp_stat;

    // tree node index of the block of order ord at unit address addr
    function automatic logic [IDX_W-1:0] node_idx(input logic [3:0] ord,
                                                  input logic [UNIT_W-1:0] addr);
        logic [IDX_W-1:0] base;
        base = (IDX_W'(1) << (4'(MAX_ORDER) - ord)) - IDX_W'(1);
        return base + ({1'b0, addr} >> ord);
    endfunction

endpackage

// File: src/bba_ctrl.sv
`timescale 1ns / 1ps
module bba_ctrl import bba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_wr,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NONE;
        o_cmd.opx  = OPX_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.op = OP_CLR;
                if (i_stat.clr_done) n_state = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.op = OP_ROOT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = !i_cfg_wr;
                if (i_in_valid && !i_cfg_wr) begin
                    o_cmd.op = OP_CAP;
                    n_state  = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.op = OP_DEC;
                if (i_stat.dec_err)      n_state = S_DONE;
                else if (i_stat.is_free) n_state = S_UNIT_RD;
                else                     n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.op = OP_SCAN_RD;
                n_state  = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                o_cmd.op = OP_SCAN_CHK;
                n_state  = i_stat.hit ? S_TAKE_RD : S_SCAN_RD;
            end
            S_TAKE_RD: begin
                o_cmd.op = OP_NODE_RD;
                n_state  = S_TAKE_WR;
            end
            S_TAKE_WR: begin
                o_cmd.op = OP_TAKE_WR;
                n_state  = i_stat.more ? S_SPLIT_PREP : S_UNIT_WR;
            end
            S_SPLIT_PREP: begin
                o_cmd.op = OP_SPLIT_PREP;
                n_state  = S_SPLIT_RD;
            end
            S_SPLIT_RD: begin
                o_cmd.op = OP_NODE_RD;
                n_state  = S_SPLIT_WR;
            end
            S_SPLIT_WR: begin
                o_cmd.op = OP_SPLIT_WR;
                n_state  = i_stat.more ? S_SPLIT_PREP : S_UNIT_WR;
            end
            S_UNIT_WR: begin
                o_cmd.op = OP_UNIT_WR;
                n_state  = S_DONE;
            end
            S_UNIT_RD: begin
                o_cmd.op = OP_UNIT_RD;
                n_state  = S_FR_CHK;
            end
            S_FR_CHK: begin
                o_cmd.op = OP_FR_CHK;
                n_state  = i_stat.fr_err ? S_DONE : S_MG_PREP;
            end
            S_MG_PREP: begin
                o_cmd.op = OP_MG_PREP;
                n_state  = i_stat.merge_ok ? S_MG_RD : S_SET_PREP;
            end
            S_MG_RD: begin
                o_cmd.op = OP_NODE_RD;
                n_state  = S_MG_CHK;
            end
            S_MG_CHK: begin
                o_cmd.op = OP_MG_CHK;
                n_state  = i_stat.buddy_free ? S_MG_PREP : S_SET_PREP;
            end
            S_SET_PREP: begin
                o_cmd.opx = OPX_SET_PREP;
                n_state   = S_SET_RD;
            end
            S_SET_RD: begin
                o_cmd.op = OP_NODE_RD;
                n_state  = S_SET_WR;
            end
            S_SET_WR: begin
                o_cmd.opx = OPX_SET_WR;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.opx = OPX_OUT;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
        // a pool_order write restarts the clearing pass
        if (i_cfg_wr) n_state = S_CLR;
    end

endmodule

// File: src/bba_datapath.sv
`timescale 1ns / 1ps
module bba_datapath import bba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic              i_cfg_wr,
    input  logic [3:0]        i_cfg_pool,
    input  logic              i_cmd_bit,
    input  logic [14:0]       i_size_bytes,
    input  logic [UNIT_W-1:0] i_block_unit,
    input  logic              i_out_ready,
    output t_dp_stat          o_stat,
    output logic [3:0]        o_pool,
    output logic              o_out_valid,
    output logic [1:0]        o_status,
    output logic [UNIT_W-1:0] o_granted_unit,
    output logic [3:0]        o_granted_order
);

    // node free flags, 32 per word; unit table {allocated, order}
    logic [WBITS-1:0] r_nf_mem [NWORDS];
    logic [4:0]       r_um_mem [NUNITS];
    logic [WBITS-1:0] r_nf_q;
    logic [4:0]       r_um_q;

    logic [3:0]        r_pool;
    logic [IDX_W-1:0]  r_cnt [MAX_ORDER+1];
    logic [UNIT_W-1:0] r_clr;
    logic              r_out_valid;

    logic              r_cmd;
    logic [14:0]       r_size;
    logic [UNIT_W-1:0] r_unit;
    logic [3:0]        r_need, r_ord;
    logic [UNIT_W-1:0] r_addr;
    logic [IDX_W-1:0]  r_idx, r_lo, r_hi;
    logic [WADR_W-1:0] r_w;
    t_status           r_res_st;
    logic [UNIT_W-1:0] r_res_unit;
    logic [3:0]        r_res_ord;

    logic [11:0]       c_units;
    logic [3:0]        c_need, c_ford, c_fr_ord, c_nord;
    logic              c_bad, c_fnd, c_inv;
    logic [IDX_W-1:0]  c_base, c_hi, c_hidx, c_off, c_root, c_bidx;
    logic [WBITS-1:0]  c_hvec, c_bit;
    logic [WSEL_W-1:0] c_hb;
    logic              c_hit;

    logic              c_nf_we, c_um_we;
    logic [WADR_W-1:0] c_nf_wa, c_nf_ra;
    logic [WBITS-1:0]  c_nf_wd;
    logic [UNIT_W-1:0] c_um_wa, c_um_ra;
    logic [4:0]        c_um_wd;

    // size decode and order choice from the per-order free counts
    always_comb begin
        c_units = 12'((16'(r_size) + 16'(UNIT_BYTES - 1)) >> UNIT_SHIFT);
        c_need  = 4'(MAX_ORDER + 2);
        for (int n = MAX_ORDER + 1; n >= 0; n--) begin
            if ((12'd1 << n) >= c_units) c_need = 4'(n);
        end
        c_bad  = (r_size == 15'd0) || (c_need > r_pool);
        c_fnd  = 1'b0;
        c_ford = 4'd0;
        for (int o = MAX_ORDER; o >= 0; o--) begin
            if (4'(o) >= c_need && 4'(o) <= r_pool && r_cnt[o] != '0) begin
                c_fnd  = 1'b1;
                c_ford = 4'(o);
            end
        end
        c_base = (IDX_W'(1) << (4'(MAX_ORDER) - c_ford)) - IDX_W'(1);
        c_hi   = c_base + ((IDX_W'(1) << (r_pool - c_ford)) - IDX_W'(1));
        c_inv  = {1'b0, r_unit} >= (IDX_W'(1) << r_pool);
        c_fr_ord = (r_um_q[3:0] > r_pool) ? r_pool : r_um_q[3:0];
        c_nord = r_ord - 4'd1;
        c_root = node_idx(r_pool, '0);
        c_bit  = WBITS'(1) << r_idx[WSEL_W-1:0];
    end

    // scan of one memory word for the lowest free node in range
    always_comb begin
        for (int b = 0; b < WBITS; b++) begin
            c_bidx    = {r_w, WSEL_W'(b)};
            c_hvec[b] = r_nf_q[b] && (c_bidx >= r_lo) && (c_bidx <= r_hi);
        end
        c_bidx = '0;
        c_hb   = '0;
        for (int b = WBITS - 1; b >= 0; b--) begin
            if (c_hvec[b]) c_hb = WSEL_W'(b);
        end
        c_hit  = |c_hvec;
        c_hidx = {r_w, c_hb};
        c_off  = (c_hidx - r_lo) << r_ord;
    end

    // memory port control
    always_comb begin
        c_nf_we = 1'b0;
        c_nf_wa = r_idx[IDX_W-1:WSEL_W];
        c_nf_wd = r_nf_q;
        c_nf_ra = r_idx[IDX_W-1:WSEL_W];
        c_um_we = 1'b0;
        c_um_wa = r_addr;
        c_um_wd = '0;
        c_um_ra = r_unit;
        case (i_cmd.op)
            OP_CLR: begin
                c_nf_we = 1'b1;
                c_nf_wa = r_clr[WADR_W-1:0];
                c_nf_wd = '0;
                c_um_we = 1'b1;
                c_um_wa = r_clr;
            end
            OP_ROOT: begin
                c_nf_we = 1'b1;
                c_nf_wa = c_root[IDX_W-1:WSEL_W];
                c_nf_wd = WBITS'(1) << c_root[WSEL_W-1:0];
            end
            OP_SCAN_RD: c_nf_ra = r_w;
            OP_TAKE_WR: begin
                c_nf_we = 1'b1;
                c_nf_wd = r_nf_q & ~c_bit;
            end
            OP_MG_CHK: begin
                c_nf_we = r_nf_q[r_idx[WSEL_W-1:0]];
                c_nf_wd = r_nf_q & ~c_bit;
            end
            OP_SPLIT_WR: begin
                c_nf_we = 1'b1;
                c_nf_wd = r_nf_q | c_bit;
            end
            OP_UNIT_WR: begin
                c_um_we = 1'b1;
                c_um_wd = {1'b1, r_need};
            end
            OP_FR_CHK: begin
                c_um_we = r_um_q[4];
                c_um_wa = r_unit;
            end
            default: ;
        endcase
        if (i_cmd.opx == OPX_SET_WR) begin
            c_nf_we = 1'b1;
            c_nf_wd = r_nf_q | c_bit;
        end
    end

    // memories with registered read
    always_ff @(posedge i_clk) begin
        if (c_nf_we) r_nf_mem[c_nf_wa] <= c_nf_wd;
        r_nf_q <= r_nf_mem[c_nf_ra];
        if (c_um_we) r_um_mem[c_um_wa] <= c_um_wd;
        r_um_q <= r_um_mem[c_um_ra];
    end

    // control registers: pool size, free counts, sweep counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool      <= 4'(MAX_ORDER);
            r_clr       <= '0;
            r_out_valid <= 1'b0;
            for (int o = 0; o <= MAX_ORDER; o++) r_cnt[o] <= '0;
        end else begin
            if (i_cfg_wr) begin
                r_pool <= (i_cfg_pool > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : i_cfg_pool;
                r_clr  <= '0;
            end else if (i_cmd.op == OP_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            case (i_cmd.op)
                OP_CLR:  for (int o = 0; o <= MAX_ORDER; o++) r_cnt[o] <= '0;
                OP_ROOT: r_cnt[r_pool] <= IDX_W'(1);
                OP_TAKE_WR, OP_SPLIT_WR: begin
                    if (i_cmd.op == OP_TAKE_WR) r_cnt[r_ord] <= r_cnt[r_ord] - 1'b1;
                    else                        r_cnt[r_ord] <= r_cnt[r_ord] + 1'b1;
                end
                OP_MG_CHK: begin
                    if (r_nf_q[r_idx[WSEL_W-1:0]]) r_cnt[r_ord] <= r_cnt[r_ord] - 1'b1;
                end
                default: ;
            endcase
            if (i_cmd.opx == OPX_SET_WR) r_cnt[r_ord] <= r_cnt[r_ord] + 1'b1;
            if (i_cmd.opx == OPX_OUT)  r_out_valid <= 1'b1;
            else if (i_out_ready)      r_out_valid <= 1'b0;
        end
    end

    // request payload and walk registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAP: begin
                r_cmd  <= i_cmd_bit;
                r_size <= i_size_bytes;
                r_unit <= i_block_unit;
            end
            OP_DEC: begin
                r_need     <= c_need;
                r_ord      <= c_ford;
                r_lo       <= c_base;
                r_hi       <= c_hi;
                r_w        <= c_base[IDX_W-1:WSEL_W];
                r_res_unit <= '0;
                r_res_ord  <= '0;
                if (r_cmd)      r_res_st <= ST_INV_FREE;
                else if (c_bad) r_res_st <= ST_BAD_SIZE;
                else            r_res_st <= ST_OOM;
            end
            OP_SCAN_CHK: begin
                if (c_hit) begin
                    r_idx  <= c_hidx;
                    r_addr <= c_off[UNIT_W-1:0];
                end else begin
                    r_w <= r_w + 1'b1;
                end
            end
            OP_SPLIT_PREP: begin
                r_ord <= c_nord;
                r_idx <= node_idx(c_nord, r_addr + (UNIT_W'(1) << c_nord));
            end
            OP_UNIT_WR: begin
                r_res_st   <= ST_OK;
                r_res_unit <= r_addr;
                r_res_ord  <= r_need;
            end
            OP_FR_CHK: begin
                r_res_st <= ST_INV_FREE;
                r_ord    <= c_fr_ord;
                r_addr   <= r_unit;
            end
            OP_MG_PREP: r_idx <= node_idx(r_ord, r_addr ^ (UNIT_W'(1) << r_ord));
            OP_MG_CHK: begin
                if (r_nf_q[r_idx[WSEL_W-1:0]]) begin
                    r_addr <= r_addr & ~(UNIT_W'(1) << r_ord);
                    r_ord  <= r_ord + 4'd1;
                end
            end
            default: ;
        endcase
        case (i_cmd.opx)
            OPX_SET_PREP: r_idx <= node_idx(r_ord, r_addr);
            OPX_SET_WR: begin
                r_res_st   <= ST_OK;
                r_res_unit <= '0;
                r_res_ord  <= r_ord;
            end
            OPX_OUT: begin
                o_status        <= r_res_st;
                o_granted_unit  <= r_res_unit;
                o_granted_order <= r_res_ord;
            end
            default: ;
        endcase
    end

    // status back to the controller
    always_comb begin
        o_stat.dec_err    = r_cmd ? c_inv : (c_bad || !c_fnd);
        o_stat.fr_err     = !r_um_q[4];
        o_stat.is_free    = r_cmd;
        o_stat.hit        = c_hit;
        o_stat.more       = r_ord > r_need;
        o_stat.merge_ok   = r_ord < r_pool;
        o_stat.buddy_free = r_nf_q[r_idx[WSEL_W-1:0]];
        o_stat.clr_done   = &r_clr;
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_pool      = r_pool;
    assign o_out_valid = r_out_valid;

endmodule

// File: src/buddy_block_allocator_top.sv
`timescale 1ns / 1ps
// Buddy allocator over a pool of 2^pool_order 16-byte units (pool_order up to 10,
// reset 10). Each input word is an allocate (cmd 0, size in bytes) or a free
// (cmd 1, unit address) and yields one result word with status, unit and order.
// After reset and after every pool_order write the block runs a clearing pass
// through its node and unit memories before it takes words.
// Requests are handled one at a time by a sequencer around memories with
// registered read: a bad size, out of memory or a free beyond the pool ends
// at decode, and a free of an unallocated unit after its unit table check;
// an allocate scans the 32-node memory words at the chosen order (up to 33)
// and then splits, and a free merges with free buddies level by level until
// a busy buddy or pool_order ends the merge.
// A finished result waits in the output register while the next word is taken.
module buddy_block_allocator_top import bba_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [14:0]       i_size_bytes,
    input  logic [UNIT_W-1:0] i_block_unit,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic [UNIT_W-1:0] o_granted_unit,
    output logic [3:0]        o_granted_order
);

    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;
    logic       w_cfg_wr;
    logic [3:0] w_pool;

    // register file: pool_order at address 0
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata   = (paddr[2] == 1'b0) ? {28'd0, w_pool} : 32'd0;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (w_cfg_wr),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    bba_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_cfg_wr        (w_cfg_wr),
        .i_cfg_pool      (pwdata[3:0]),
        .i_cmd_bit       (i_cmd),
        .i_size_bytes    (i_size_bytes),
        .i_block_unit    (i_block_unit),
        .i_out_ready     (i_out_ready),
        .o_stat          (w_stat),
        .o_pool          (w_pool),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_granted_unit  (o_granted_unit),
        .o_granted_order (o_granted_order)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
    import bba_pkg::*;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_cmd = 1'b0;
    logic [14:0]       i_size_bytes = '0;
    logic [UNIT_W-1:0] i_block_unit = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [1:0]        o_status;
    logic [UNIT_W-1:0] o_granted_unit;
    logic [3:0]        o_granted_order;

    localparam int NNODES = (2 << MAX_ORDER) - 1;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [1:0]        status;
        logic [UNIT_W-1:0] unit;
        logic [3:0]        order;
    } t_grant;

    // allocator shadow state
    bit          shadow_free[NNODES];
    logic [3:0]  shadow_order[NUNITS];
    bit          shadow_alloc[NUNITS];
    int          shadow_pool;
    logic [UNIT_W-1:0] live_blocks[$];

    t_grant grant_q[$];
    int     err_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    buddy_block_allocator_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int node_of(int ord, int addr);
        return ((1 << (MAX_ORDER - ord)) - 1) + (addr >> ord);
    endfunction

    function automatic void pool_reset(int ord);
        shadow_pool = ord > MAX_ORDER ? MAX_ORDER : ord;
        foreach (shadow_free[i]) shadow_free[i] = 0;
        foreach (shadow_order[i]) shadow_order[i] = '0;
        foreach (shadow_alloc[i]) shadow_alloc[i] = 0;
        shadow_free[node_of(shadow_pool, 0)] = 1;
        live_blocks.delete();
    endfunction

    // compute the expected grant for one request and update the shadow pool
    function automatic t_grant predict_grant(bit cmd, int size, int unit);
        t_grant g;
        int units, need, ord, addr, idx;
        bit found;
        g = '0;
        if (cmd == 1'b0) begin
            if (size == 0) begin
                g.status = ST_BAD_SIZE;
                return g;
            end
            units = (size + UNIT_BYTES - 1) / UNIT_BYTES;
            need = 0;
            while (need < 20 && (1 << need) < units) need++;
            if (need > shadow_pool) begin
                g.status = ST_BAD_SIZE;
                return g;
            end
            found = 0;
            addr = 0;
            for (ord = need; ord <= shadow_pool && !found; ord++)
                for (int k = 0; k < (1 << (shadow_pool - ord)); k++)
                    if (shadow_free[node_of(ord, k << ord)]) begin
                        addr = k << ord;
                        found = 1;
                        break;
                    end
            if (!found) begin
                g.status = ST_OOM;
                return g;
            end
            ord--;
            shadow_free[node_of(ord, addr)] = 0;
            while (ord > need) begin
                ord--;
                shadow_free[node_of(ord, addr + (1 << ord))] = 1;
            end
            shadow_alloc[addr] = 1;
            shadow_order[addr] = 4'(need);
            live_blocks.push_back(UNIT_W'(addr));
            g.status = ST_OK;
            g.unit = UNIT_W'(addr);
            g.order = 4'(need);
        end else begin
            if (unit >= (1 << shadow_pool) || !shadow_alloc[unit]) begin
                g.status = ST_INV_FREE;
                return g;
            end
            ord = shadow_order[unit];
            if (ord > shadow_pool) ord = shadow_pool;
            shadow_alloc[unit] = 0;
            shadow_order[unit] = '0;
            while (ord < shadow_pool) begin
                idx = node_of(ord, unit ^ (1 << ord));
                if (!shadow_free[idx]) break;
                shadow_free[idx] = 0;
                unit &= ~(1 << ord);
                ord++;
            end
            shadow_free[node_of(ord, unit)] = 1;
            g.status = ST_OK;
            g.order = 4'(ord);
        end
        return g;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d want %0d at cycle %0d", what, got, want,
                 cycle_count);
        err_count++;
    endtask

    // cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        t_grant want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (grant_q.size() == 0) begin
                report_mismatch("unexpected word", o_status, -1);
            end else begin
                want = grant_q.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_granted_unit != want.unit)
                    report_mismatch("granted_unit", o_granted_unit, want.unit);
                if (o_granted_order != want.order)
                    report_mismatch("granted_order", o_granted_order, want.order);
            end
        end
    end

    // send one request word; prediction is made at acceptance
    // valid drops only when the sender idles, so back to back words keep it high
    task automatic send_request(bit cmd, int size, int unit);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid   <= 1'b1;
        i_cmd        <= cmd;
        i_size_bytes <= size[14:0];
        i_block_unit <= unit[UNIT_W-1:0];
        do @(posedge i_clk); while (!o_in_ready);
        grant_q.push_back(predict_grant(cmd, size, unit));
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (grant_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    // APB write; the block rebuilds its pool afterwards
    task automatic write_pool_order(int val);
        drain();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        pool_reset(val & 4'hf);
    endtask

    task automatic alloc_req(int size);
        send_request(1'b0, size, $urandom_range(NUNITS - 1));
    endtask

    task automatic free_req(int unit);
        send_request(1'b1, $urandom_range(16384), unit);
    endtask

    function automatic int pick_live();
        int k, u;
        k = $urandom_range(live_blocks.size() - 1);
        u = live_blocks[k];
        live_blocks.delete(k);
        return u;
    endfunction

    task automatic test_directed();
        alloc_req(0);
        alloc_req(16385);
        alloc_req(32767);
        alloc_req(16384);
        free_req(0);
        free_req(0);
        alloc_req(1);
        alloc_req(16);
        alloc_req(17);
        alloc_req(1000);
        free_req(1023);
        free_req(5);
        free_req(16);
        free_req(0);
        free_req(32);
        free_req(64);
        write_pool_order(0);
        alloc_req(17);
        alloc_req(16);
        alloc_req(16);
        free_req(1);
        free_req(0);
        write_pool_order(15);
        alloc_req(16384);
        alloc_req(1);
    endtask

    task automatic random_burst(int n);
        int r, sz;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            if (r < 50) begin
                // mostly small sizes, some large
                sz = ($urandom_range(9) == 0) ? $urandom_range(32767)
                                              : $urandom_range(1, 16 << $urandom_range(5));
                alloc_req(sz);
            end else if (r < 88 && live_blocks.size() != 0) begin
                free_req(pick_live());
            end else if (r < 94) begin
                free_req($urandom_range(NUNITS - 1));
            end else begin
                send_request(1'b0, $urandom_range(1) ? 0 : $urandom_range(32767),
                             $urandom_range(NUNITS - 1));
            end
        end
    endtask

    task automatic test_random();
        int orders[6] = '{10, 3, 6, 1, 8, 10};
        for (int p = 0; p < 6; p++) begin
            write_pool_order(orders[p]);
            case (p)
                0: begin send_idle_pct = 29; recv_idle_pct = 56; end
                2: begin send_idle_pct = 56; recv_idle_pct = 29; end
                4: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                default: ;
            endcase
            random_burst(150);
        end
    endtask

    initial begin
        pool_reset(MAX_ORDER);
        send_idle_pct = 29;
        recv_idle_pct = 56;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random();
        drain();
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
